/* hdl/pidc_pkg.sv */
// Package for the clamped PID unit: widths, microcode word, divider structs.
// Holds the read-only control program; used by pidc_div and the top level.
// No dependencies.
package pidc_pkg;

   localparam int GAIN_W   = 8;
   localparam int LIM_W    = 15;
   localparam int VAL_W    = 16;
   localparam int DT_W     = 16;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int PTERM_W  = 26;
   localparam int INTEG_W  = 32;
   localparam int MUL_A_W  = 27;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int DVD_W    = 42;
   localparam int QUOT_W   = 38;
   localparam int SUM_W    = 38;
   localparam int DIV_ITERS = DVD_W / 2;
   localparam int CNT_W    = $clog2(DIV_ITERS);
   localparam int MS_PER_S = 1000;
   localparam int STEP_W   = 4;

   // division by 1000 in 14-bit chunks: floor(n / 1000) = (n * ceil(2^34 / 1000)) >> 34
   // holds for every chunk numerator n below 1000 * 2^14
   localparam int MS_CHUNK_W = 14;
   localparam int MS_REM_W   = 10;
   localparam int MS_N_W     = MS_REM_W + MS_CHUNK_W;
   localparam int MS_RECIP_W = 25;
   localparam int MS_SHIFT   = 34;
   localparam int MS_STEPS   = DVD_W / MS_CHUNK_W;
   localparam logic [MS_RECIP_W-1:0] MS_RECIP = 25'd17179870;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE  = 4'd0;
   localparam step_type STEP_FIRST = 4'd1;
   localparam step_type STEP_PTERM = 4'd2;
   localparam step_type STEP_IMUL  = 4'd3;
   localparam step_type STEP_IDIV  = 4'd4;
   localparam step_type STEP_IWAIT = 4'd5;
   localparam step_type STEP_INTEG = 4'd6;
   localparam step_type STEP_DMUL  = 4'd7;
   localparam step_type STEP_DDIV  = 4'd8;
   localparam step_type STEP_DWAIT = 4'd9;
   localparam step_type STEP_SUM   = 4'd10;
   localparam step_type STEP_EMIT  = 4'd11;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_GP_ERR, MUL_GI_ERR, MUL_PROD_DT, MUL_GD_DIFF, MUL_PROD_MS
   } mul_sel_type;

   typedef enum logic [1:0] {DIV_NONE, DIV_BY_MS, DIV_BY_DT} div_sel_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_FIRST, ACT_PTERM, ACT_INTEG, ACT_SUM, ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      BR_NEXT, BR_WAIT_REQ, BR_IF_FIRST, BR_WAIT_DIV, BR_WAIT_OUT
   } br_type;

   typedef struct packed {
      mul_sel_type mul;
      div_sel_type div;
      act_type     act;
      br_type      br;
      step_type    target;
   } uword_type;

   typedef struct packed {
      logic                     start;
      logic                     by_ms;
      logic signed [PROD_W-1:0] dividend;
      logic [DT_W-1:0]          divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic signed [QUOT_W-1:0] quot;
   } div_rsp_type;

   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{mul: MUL_NONE, div: DIV_NONE, act: ACT_NONE, br: BR_NEXT, target: STEP_IDLE};
      case (step)
         STEP_IDLE:  w.br = BR_WAIT_REQ;
         STEP_FIRST: begin
            w.mul = MUL_GP_ERR;
            w.act = ACT_FIRST;
            w.br  = BR_IF_FIRST;
         end
         STEP_PTERM: begin
            w.mul = MUL_GI_ERR;
            w.act = ACT_PTERM;
         end
         STEP_IMUL:  w.mul = MUL_PROD_DT;
         STEP_IDIV:  w.div = DIV_BY_MS;
         STEP_IWAIT: w.br  = BR_WAIT_DIV;
         STEP_INTEG: begin
            w.mul = MUL_GD_DIFF;
            w.act = ACT_INTEG;
         end
         STEP_DMUL:  w.mul = MUL_PROD_MS;
         STEP_DDIV:  w.div = DIV_BY_DT;
         STEP_DWAIT: w.br  = BR_WAIT_DIV;
         STEP_SUM:   w.act = ACT_SUM;
         STEP_EMIT:  begin
            w.act = ACT_EMIT;
            w.br  = BR_WAIT_OUT;
         end
         default:    w.br  = BR_NEXT;
      endcase
      return w;
   endfunction

endpackage

/* hdl/pid_controller_clamped_unit.sv */
// Clamped PID controller top level: microcoded sequencer, datapath, APB registers.
// Depends on pidc_pkg and pidc_div.
//
//   channel | handshake           | payload
//   req     | req_valid/req_ready | req_set_point, req_depth, req_elapsed_ms
//   rsp     | rsp_valid/rsp_ready | rsp_drive, rsp_clamped
//   csr     | psel/penable/pready | pwrite, paddr, pwdata, prdata
//
// Item time is set mostly by 21 radix-4 iterations dividing by elapsed time; the
// integral's division by 1000 takes 3 reciprocal steps; a first sample skips both.
// req_ready is high only while the program sits at its idle step.
// The result register frees the input side; the program stalls at its last step
// only while an earlier result is still waiting for transfer.
// Synchronous active-high reset clears state and loads default gains and limit.
module pid_controller_clamped_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [pidc_pkg::VAL_W-1:0]  req_set_point,
   input  logic signed [pidc_pkg::VAL_W-1:0]  req_depth,
   input  logic        [pidc_pkg::DT_W-1:0]   req_elapsed_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pidc_pkg::VAL_W-1:0]  rsp_drive,
   output logic                               rsp_clamped,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic        [3:0]                  paddr,
   input  logic        [31:0]                 pwdata,
   output logic        [31:0]                 prdata,
   output logic                               pready
);

   localparam logic [1:0] REG_GAIN_PROP   = 2'd0;
   localparam logic [1:0] REG_GAIN_INTEG  = 2'd1;
   localparam logic [1:0] REG_GAIN_DERIV  = 2'd2;
   localparam logic [1:0] REG_DRIVE_LIMIT = 2'd3;

   logic [pidc_pkg::GAIN_W-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [pidc_pkg::LIM_W-1:0]  drive_limit_ff;

   pidc_pkg::step_type                step_ff, step_in;
   logic                              seen_ff;
   logic signed [pidc_pkg::VAL_W-1:0] held_sp_ff;
   logic signed [pidc_pkg::ERR_W-1:0] err_ff;
   logic signed [pidc_pkg::DIFF_W-1:0] prev_err_ff;
   logic [pidc_pkg::DT_W-1:0]         dt_ff;
   logic signed [pidc_pkg::INTEG_W-1:0] integ_ff;
   logic signed [pidc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pidc_pkg::PTERM_W-1:0] pterm_ff;
   logic signed [pidc_pkg::SUM_W-1:0] sum_ff;
   logic                              rsp_valid_ff;
   logic signed [pidc_pkg::VAL_W-1:0] rsp_drive_ff;
   logic                              rsp_clamped_ff;

   pidc_pkg::uword_type               uw;
   pidc_pkg::div_req_type             div_req;
   pidc_pkg::div_rsp_type             div_rsp;
   logic                              req_xfer, out_busy, csr_wr;
   logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pidc_pkg::DIFF_W-1:0] diff;
   logic signed [pidc_pkg::ERR_W-1:0] err_new;
   logic signed [pidc_pkg::INTEG_W+1:0] isum;
   logic signed [pidc_pkg::INTEG_W-1:0] isat;
   logic signed [pidc_pkg::SUM_W-1:0] lim_pos, lim_neg;
   logic signed [pidc_pkg::VAL_W-1:0] drive_new;
   logic                              clamp_new;

   assign uw        = pidc_pkg::ucode(step_ff);
   assign req_ready = (step_ff == pidc_pkg::STEP_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   always_comb begin
      case (paddr[3:2])
         REG_GAIN_PROP:   prdata = 32'(gain_prop_ff);
         REG_GAIN_INTEG:  prdata = 32'(gain_integ_ff);
         REG_GAIN_DERIV:  prdata = 32'(gain_deriv_ff);
         REG_DRIVE_LIMIT: prdata = 32'(drive_limit_ff);
         default:         prdata = '0;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      diff    = prev_err_ff - pidc_pkg::DIFF_W'(err_ff);
      err_new = pidc_pkg::ERR_W'(req_set_point) - pidc_pkg::ERR_W'(req_depth);
      mul_a   = '0;
      mul_b   = '0;
      case (uw.mul)
         pidc_pkg::MUL_GP_ERR: begin
            mul_a = pidc_pkg::MUL_A_W'(err_ff);
            mul_b = pidc_pkg::MUL_B_W'($signed({1'b0, gain_prop_ff}));
         end
         pidc_pkg::MUL_GI_ERR: begin
            mul_a = pidc_pkg::MUL_A_W'(err_ff);
            mul_b = pidc_pkg::MUL_B_W'($signed({1'b0, gain_integ_ff}));
         end
         pidc_pkg::MUL_PROD_DT: begin
            mul_a = $signed(prod_ff[pidc_pkg::MUL_A_W-1:0]);
            mul_b = $signed({1'b0, dt_ff});
         end
         pidc_pkg::MUL_GD_DIFF: begin
            mul_a = pidc_pkg::MUL_A_W'(diff);
            mul_b = pidc_pkg::MUL_B_W'($signed({1'b0, gain_deriv_ff}));
         end
         pidc_pkg::MUL_PROD_MS: begin
            mul_a = $signed(prod_ff[pidc_pkg::MUL_A_W-1:0]);
            mul_b = pidc_pkg::MUL_B_W'(pidc_pkg::MS_PER_S);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      div_req.start    = (uw.div != pidc_pkg::DIV_NONE);
      div_req.by_ms    = (uw.div == pidc_pkg::DIV_BY_MS);
      div_req.dividend = prod_ff;
      div_req.divisor  = dt_ff;
   end

   pidc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // integral update with 32-bit saturation
   always_comb begin
      isum = (pidc_pkg::INTEG_W+2)'(integ_ff)
           + (pidc_pkg::INTEG_W+2)'($signed(div_rsp.quot[pidc_pkg::INTEG_W:0]));
      if (isum[pidc_pkg::INTEG_W+1:pidc_pkg::INTEG_W-1] == 3'b000 ||
          isum[pidc_pkg::INTEG_W+1:pidc_pkg::INTEG_W-1] == 3'b111) begin
         isat = isum[pidc_pkg::INTEG_W-1:0];
      end else if (isum[pidc_pkg::INTEG_W+1]) begin
         isat = {1'b1, {(pidc_pkg::INTEG_W-1){1'b0}}};
      end else begin
         isat = {1'b0, {(pidc_pkg::INTEG_W-1){1'b1}}};
      end
   end

   // output clamp
   always_comb begin
      lim_pos   = $signed({{(pidc_pkg::SUM_W-pidc_pkg::LIM_W){1'b0}}, drive_limit_ff});
      lim_neg   = -lim_pos;
      clamp_new = 1'b0;
      drive_new = sum_ff[pidc_pkg::VAL_W-1:0];
      if (sum_ff > lim_pos) begin
         clamp_new = 1'b1;
         drive_new = lim_pos[pidc_pkg::VAL_W-1:0];
      end else if (sum_ff < lim_neg) begin
         clamp_new = 1'b1;
         drive_new = lim_neg[pidc_pkg::VAL_W-1:0];
      end
   end

   always_comb begin
      case (uw.br)
         pidc_pkg::BR_WAIT_REQ: step_in = req_xfer ? step_ff + pidc_pkg::STEP_W'(1) : step_ff;
         pidc_pkg::BR_IF_FIRST: step_in = !seen_ff ? uw.target
                                                   : step_ff + pidc_pkg::STEP_W'(1);
         pidc_pkg::BR_WAIT_DIV: step_in = div_rsp.busy ? step_ff
                                                       : step_ff + pidc_pkg::STEP_W'(1);
         pidc_pkg::BR_WAIT_OUT: step_in = out_busy ? step_ff : uw.target;
         default:               step_in = step_ff + pidc_pkg::STEP_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= pidc_pkg::GAIN_W'(10);
         gain_integ_ff  <= pidc_pkg::GAIN_W'(10);
         gain_deriv_ff  <= pidc_pkg::GAIN_W'(10);
         drive_limit_ff <= pidc_pkg::LIM_W'(16128);
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_GAIN_PROP:   gain_prop_ff   <= pwdata[pidc_pkg::GAIN_W-1:0];
            REG_GAIN_INTEG:  gain_integ_ff  <= pwdata[pidc_pkg::GAIN_W-1:0];
            REG_GAIN_DERIV:  gain_deriv_ff  <= pwdata[pidc_pkg::GAIN_W-1:0];
            REG_DRIVE_LIMIT: drive_limit_ff <= pwdata[pidc_pkg::LIM_W-1:0];
            default:         gain_prop_ff   <= gain_prop_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= pidc_pkg::STEP_IDLE;
         seen_ff      <= 1'b0;
         held_sp_ff   <= '0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (rsp_valid_ff && rsp_ready && uw.act != pidc_pkg::ACT_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_xfer && req_set_point != held_sp_ff) begin
            held_sp_ff <= req_set_point;
            integ_ff   <= '0;
         end
         case (uw.act)
            pidc_pkg::ACT_FIRST: begin
               if (!seen_ff) begin
                  seen_ff     <= 1'b1;
                  prev_err_ff <= pidc_pkg::DIFF_W'(err_ff);
               end
            end
            pidc_pkg::ACT_INTEG: integ_ff <= isat;
            pidc_pkg::ACT_SUM:   prev_err_ff <= pidc_pkg::DIFF_W'(err_ff);
            pidc_pkg::ACT_EMIT: begin
               if (!out_busy) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: seen_ff <= seen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         err_ff <= err_new;
         dt_ff  <= (req_elapsed_ms == '0) ? pidc_pkg::DT_W'(1) : req_elapsed_ms;
      end
      if (uw.mul != pidc_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (uw.act == pidc_pkg::ACT_PTERM) begin
         pterm_ff <= prod_ff[pidc_pkg::PTERM_W-1:0];
      end
      if (uw.act == pidc_pkg::ACT_SUM) begin
         sum_ff <= pidc_pkg::SUM_W'(pterm_ff) + pidc_pkg::SUM_W'(integ_ff) + div_rsp.quot;
      end
      if (uw.act == pidc_pkg::ACT_EMIT && !out_busy) begin
         rsp_drive_ff   <= drive_new;
         rsp_clamped_ff <= clamp_new;
      end
   end

   a_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (step_ff == pidc_pkg::STEP_IDLE))
      else $error("input transfer outside idle step");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (step_ff == pidc_pkg::STEP_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while sequencer idle");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped) |->
         (rsp_drive == $signed({1'b0, drive_limit_ff}) ||
          rsp_drive == -$signed({1'b0, drive_limit_ff})))
      else $error("clamped result not at limit");

   a_unclamped_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_clamped) |->
         (rsp_drive <= $signed({1'b0, drive_limit_ff}) &&
          rsp_drive >= -$signed({1'b0, drive_limit_ff})))
      else $error("unclamped result beyond limit");

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      (step_ff == pidc_pkg::STEP_EMIT && !out_busy) |=> (step_ff == pidc_pkg::STEP_IDLE))
      else $error("sequencer did not return to idle after result");

endmodule

/* hdl/pidc_div.sv */
// Signed divider truncating toward zero: radix-4 restoring passes by a positive
// 16-bit divisor, or three reciprocal steps of 14 bits for division by 1000.
// Depends on pidc_pkg.
module pidc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pidc_pkg::div_req_type req,
   output pidc_pkg::div_rsp_type rsp
);

   logic                        busy_ff, busy_in;
   logic [pidc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pidc_pkg::DVD_W-1:0]  shreg_ff, shreg_in;
   logic [pidc_pkg::DT_W-1:0]   rem_ff, rem_in;
   logic [pidc_pkg::DT_W-1:0]   dsr_ff, dsr_in;
   logic                        neg_ff, neg_in;
   logic                        ms_ff, ms_in;

   logic [pidc_pkg::PROD_W-1:0] mag;
   logic [pidc_pkg::DT_W:0]     r1, r2, d1, d2;
   logic                        ge1, ge2;
   logic [pidc_pkg::DT_W-1:0]   rem1, rem2;
   logic [pidc_pkg::QUOT_W-1:0] qmag;
   logic [pidc_pkg::MS_N_W-1:0] ms_n, ms_r;
   logic [pidc_pkg::MS_N_W+pidc_pkg::MS_RECIP_W-1:0] ms_prod;
   logic [pidc_pkg::MS_CHUNK_W-1:0] ms_q;

   always_comb begin
      mag  = req.dividend[pidc_pkg::PROD_W-1] ? pidc_pkg::PROD_W'(-req.dividend)
                                              : pidc_pkg::PROD_W'(req.dividend);
      r1   = {rem_ff, shreg_ff[pidc_pkg::DVD_W-1]};
      ge1  = r1 >= {1'b0, dsr_ff};
      d1   = r1 - {1'b0, dsr_ff};
      rem1 = ge1 ? d1[pidc_pkg::DT_W-1:0] : r1[pidc_pkg::DT_W-1:0];
      r2   = {rem1, shreg_ff[pidc_pkg::DVD_W-2]};
      ge2  = r2 >= {1'b0, dsr_ff};
      d2   = r2 - {1'b0, dsr_ff};
      rem2 = ge2 ? d2[pidc_pkg::DT_W-1:0] : r2[pidc_pkg::DT_W-1:0];

      ms_n    = {rem_ff[pidc_pkg::MS_REM_W-1:0],
                 shreg_ff[pidc_pkg::DVD_W-1 -: pidc_pkg::MS_CHUNK_W]};
      ms_prod = (pidc_pkg::MS_N_W+pidc_pkg::MS_RECIP_W)'(ms_n)
              * (pidc_pkg::MS_N_W+pidc_pkg::MS_RECIP_W)'(pidc_pkg::MS_RECIP);
      ms_q    = ms_prod[pidc_pkg::MS_SHIFT +: pidc_pkg::MS_CHUNK_W];
      ms_r    = ms_n - pidc_pkg::MS_N_W'(ms_q) * pidc_pkg::MS_N_W'(pidc_pkg::MS_PER_S);

      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      ms_in    = ms_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         cnt_in   = req.by_ms ? pidc_pkg::CNT_W'(pidc_pkg::MS_STEPS - 1)
                              : pidc_pkg::CNT_W'(pidc_pkg::DIV_ITERS - 1);
         shreg_in = mag[pidc_pkg::DVD_W-1:0];
         rem_in   = '0;
         dsr_in   = req.divisor;
         neg_in   = req.dividend[pidc_pkg::PROD_W-1];
         ms_in    = req.by_ms;
      end else if (busy_ff) begin
         if (ms_ff) begin
            shreg_in = {shreg_ff[pidc_pkg::DVD_W-pidc_pkg::MS_CHUNK_W-1:0], ms_q};
            rem_in   = ms_r[pidc_pkg::DT_W-1:0];
         end else begin
            shreg_in = {shreg_ff[pidc_pkg::DVD_W-3:0], ge1, ge2};
            rem_in   = rem2;
         end
         cnt_in   = cnt_ff - pidc_pkg::CNT_W'(1);
         busy_in  = (cnt_ff != '0);
      end

      qmag     = shreg_ff[pidc_pkg::QUOT_W-1:0];
      rsp.busy = busy_ff;
      rsp.quot = neg_ff ? $signed(-qmag) : $signed(qmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      neg_ff   <= neg_in;
      ms_ff    <= ms_in;
   end

endmodule

/* tb/pidc_tb_pkg.sv */
`timescale 1ns / 1ps
// Register map of the clamped PID unit as seen by its testbench.
// Shared by pidc_checker and the testbench top; no dependencies.
package pidc_tb_pkg;

   typedef enum logic [1:0] {
      REG_GAIN_PROP, REG_GAIN_INTEG, REG_GAIN_DERIV, REG_DRIVE_LIMIT
   } reg_index_e;

endpackage

/* tb/pidc_checker.sv */
`timescale 1ns / 1ps
// Checker for the clamped PID unit: follows register writes and request transfers,
// predicts each drive result and compares it with the result channel in order.
// Depends on pidc_pkg and pidc_tb_pkg.
module pidc_checker
   import pidc_pkg::*;
   import pidc_tb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_set_point,
   input  logic signed [VAL_W-1:0] req_depth,
   input  logic        [DT_W-1:0]  req_elapsed_ms,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_drive,
   input  logic                    rsp_clamped,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic        [3:0]       paddr,
   input  logic        [31:0]      pwdata,
   output int                      errors,
   output int                      pending
);

   localparam int     SHOWN_MISMATCHES = 10;
   localparam longint INTEG_MAX = 64'sd2147483647;
   localparam longint INTEG_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [VAL_W-1:0] drive;
      logic                    clamped;
   } drive_out_t;

   logic        [GAIN_W-1:0]  gain_p, gain_i, gain_d;
   logic        [LIM_W-1:0]   limit;
   logic signed [INTEG_W-1:0] integ_acc;
   logic signed [DIFF_W-1:0]  last_err;
   logic signed [VAL_W-1:0]   held_sp;
   logic                      primed;
   drive_out_t                drive_q[$];
   int                        fail_count;

   // Advances the controller state by one sample; returns 1 when a drive value results.
   function automatic bit pid_step(input logic signed [VAL_W-1:0] sp,
                                   input logic signed [VAL_W-1:0] pv,
                                   input logic        [DT_W-1:0]  ms,
                                   output drive_out_t res);
      longint err, dt, p, acc, d, sum, lim;
      res = '0;
      dt = longint'(ms);
      if (dt == 0) dt = 1;
      if (sp != held_sp) begin
         held_sp = sp;
         integ_acc = '0;
      end
      err = longint'(sp) - longint'(pv);
      if (!primed) begin
         primed = 1'b1;
         last_err = DIFF_W'(err);
         return 1'b0;
      end
      p = longint'(gain_p) * err;
      acc = longint'(integ_acc) + longint'(gain_i) * err * dt / MS_PER_S;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      integ_acc = INTEG_W'(acc);
      d = longint'(gain_d) * (longint'(last_err) - err) * MS_PER_S / dt;
      sum = p + acc + d;
      lim = longint'(limit);
      if (sum > lim) begin
         sum = lim;
         res.clamped = 1'b1;
      end
      if (sum < -lim) begin
         sum = -lim;
         res.clamped = 1'b1;
      end
      last_err = DIFF_W'(err);
      res.drive = VAL_W'(sum);
      return 1'b1;
   endfunction

   function automatic void log_mismatch(input string msg);
      if (fail_count < SHOWN_MISMATCHES) $display("%0t ns: %s", $time, msg);
      fail_count++;
   endfunction

   always @(posedge clock) begin : watch
      drive_out_t want, got;
      if (reset) begin
         gain_p = 8'd10;
         gain_i = 8'd10;
         gain_d = 8'd10;
         limit = 15'd16128;
         integ_acc = '0;
         last_err = '0;
         held_sp = '0;
         primed = 1'b0;
         fail_count = 0;
         drive_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_e'(paddr[3:2]))
               REG_GAIN_PROP:   gain_p = pwdata[GAIN_W-1:0];
               REG_GAIN_INTEG:  gain_i = pwdata[GAIN_W-1:0];
               REG_GAIN_DERIV:  gain_d = pwdata[GAIN_W-1:0];
               REG_DRIVE_LIMIT: limit = pwdata[LIM_W-1:0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.drive = rsp_drive;
            got.clamped = rsp_clamped;
            if (drive_q.size() == 0) begin
               log_mismatch($sformatf("unexpected result drive %0d clamped %0b",
                                      got.drive, got.clamped));
            end else begin
               want = drive_q.pop_front();
               if (got.drive !== want.drive || got.clamped !== want.clamped)
                  log_mismatch($sformatf("drive %0d clamped %0b, expected %0d / %0b",
                                         got.drive, got.clamped, want.drive, want.clamped));
            end
         end
         if (req_valid && req_ready) begin
            if (pid_step(req_set_point, req_depth, req_elapsed_ms, want))
               drive_q.push_back(want);
         end
      end
      errors <= fail_count;
      pending <= drive_q.size();
   end

endmodule

/* tb/tb_pid_controller_clamped_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the clamped PID unit: clock, reset, sample and register stimulus.
// Depends on pidc_pkg, pidc_tb_pkg, pidc_checker and pid_controller_clamped_unit.
module tb_pid_controller_clamped_unit;
   import pidc_pkg::*;
   import pidc_tb_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 130;
   localparam int PHASES        = 6;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_set_point;
   logic signed [VAL_W-1:0] req_depth;
   logic        [DT_W-1:0]  req_elapsed_ms;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_drive;
   logic                    rsp_clamped;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic        [3:0]       paddr;
   logic        [31:0]      pwdata;
   logic        [31:0]      prdata;
   logic                    pready;
   int                      errors;
   int                      pending;
   int                      stall_cycles;
   bit                      steady;
   logic signed [VAL_W-1:0] sp_hold;

   pid_controller_clamped_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_set_point  (req_set_point),
      .req_depth      (req_depth),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drive      (rsp_drive),
      .rsp_clamped    (rsp_clamped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   pidc_checker pid_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_set_point  (req_set_point),
      .req_depth      (req_depth),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drive      (rsp_drive),
      .rsp_clamped    (rsp_clamped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .errors         (errors),
      .pending        (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [VAL_W-1:0] sp,
                              input logic signed [VAL_W-1:0] dp,
                              input logic        [DT_W-1:0]  ms);
      while (!steady && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_set_point <= sp;
      req_depth <= dp;
      req_elapsed_ms <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every predicted drive value has been transferred
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                            input logic [GAIN_W-1:0] gd, input logic [LIM_W-1:0] lim);
      write_reg(REG_GAIN_PROP, 32'(gp));
      write_reg(REG_GAIN_INTEG, 32'(gi));
      write_reg(REG_GAIN_DERIV, 32'(gd));
      write_reg(REG_DRIVE_LIMIT, 32'(lim));
   endtask

   // set point mostly held so the integral builds up; depth mostly near the set point
   task automatic send_random(input int count);
      logic signed [VAL_W-1:0] dp;
      logic        [DT_W-1:0]  ms;
      int                      pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5)
            sp_hold = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         else if (pick < 18)
            sp_hold = VAL_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 60)
            dp = sp_hold + VAL_W'($urandom_range(512)) - VAL_W'(256);
         else if (pick < 70)
            dp = pick[0] ? 16'sh7FFF : 16'sh8000;
         else
            dp = VAL_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 8)
            ms = '0;
         else if (pick < 12)
            ms = '1;
         else if (pick < 30)
            ms = DT_W'($urandom);
         else
            ms = DT_W'($urandom_range(200, 1));
         send_sample(sp_hold, dp, ms);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_set_point = '0;
      req_depth = '0;
      req_elapsed_ms = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady = 1'b0;
      sp_hold = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // first sample only primes the loop; zero elapsed time counts as one ms
      send_sample(16'sh0000, 16'sh0000, 16'h0000);
      send_sample(16'sh0000, 16'sh0000, 16'h0000);
      // full-scale errors, set point changes clear the integral
      send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh7FFF, 16'h0001);
      send_sample(16'sh8000, 16'sh7FFF, 16'h0001);
      send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF);
      send_sample(16'sh8000, 16'sh8000, 16'h0000);
      send_sample(16'sh0100, 16'sh0000, 16'd10);
      send_sample(16'sh0100, 16'sh0080, 16'd20);
      send_sample(16'sh0100, 16'sh0100, 16'd100);
      send_sample(16'sh0100, 16'sh012C, 16'hFFFF);
      drain();
      set_gains(8'd255, 8'd255, 8'd255, 15'd32767);
      // integral runs into its positive, then its negative saturation
      repeat (3) send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF);
      repeat (3) send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF);
      drain();
      set_gains(8'd1, 8'd1, 8'd1, 15'd0);
      // zero limit: a zero sum is not clamped, anything else pins drive to zero
      send_sample(16'sh0064, 16'sh0064, 16'd5);
      send_sample(16'sh0064, 16'sh0064, 16'd5);
      send_sample(16'sh0064, 16'sh0000, 16'd5);
      send_sample(16'sh0064, 16'sh00C8, 16'd5);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: set_gains(8'd255, 8'd255, 8'd255, 15'd32767);
            1: set_gains(8'd0, 8'd0, 8'd0, 15'd0);
            2: begin
               steady <= 1'b1;
               set_gains(8'($urandom), 8'($urandom), 8'($urandom), 15'($urandom));
            end
            3: set_gains(8'd1, 8'd2, 8'd0, 15'd32767);
            4: set_gains(8'($urandom), 8'($urandom), 8'($urandom), 15'($urandom));
            default: set_gains(8'd10, 8'd10, 8'd10, 15'd16128);
         endcase
         send_random(PHASE_ITEMS);
         steady <= 1'b0;
      end

      drain();
      if (errors == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
